[design/bmp_pkg.sv]
package bmp_pkg;

   localparam int MAX_IMAGE_WIDTH_DEFAULT = 4096;
   localparam int MAX_BLOCKS_PER_SIDE_DEFAULT = 64;

   localparam int WIDTH_REG_BITS = 13;
   localparam int BLOCKS_REG_BITS = 7;
   localparam int WIDTH_RESET = 512;
   localparam int BLOCKS_RESET = 8;

   localparam int CHAN_BITS = 8;
   localparam int NUM_CHAN = 3;
   localparam int SUM_BITS = 32;
   localparam int GRID_IDX_BITS = 6;
   localparam int ROW_BITS = 12;
   localparam int ROW_LIMIT = 4095;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic {
      REG_IMAGE_WIDTH = 1'b0,
      REG_BLOCKS_PER_SIDE = 1'b1
   } bmp_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MEAN,
      ST_OUT,
      ST_SIDE,
      ST_COL,
      ST_ROW
   } bmp_state_type;

endpackage

[design/bmp_ram.sv]
module bmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

[design/block_mean_pixelation.sv]
// Block-mean mosaic: RGB pixels arrive in raster order and each square block of the
// blocks_per_side x blocks_per_side grid emits its truncated mean color when its
// bottom-right pixel arrives. A pixel outside the grid is taken without a stall; a pixel
// inside stalls the input while the column sums in the block RAM are read and written
// back; a pixel that finishes a block adds the serial sum / side^2 divide and the load
// of the output register, and that load waits while an earlier result still waits
// there under stall. A finished result waits in that register while the next pixels
// are taken. After a register write the block stalls its input while it divides out
// the block side and re-derives the block coordinates of the current position (only
// the side divide when the side comes out zero).
module block_mean_pixelation #(
   parameter int MAX_IMAGE_WIDTH = bmp_pkg::MAX_IMAGE_WIDTH_DEFAULT,
   parameter int MAX_BLOCKS_PER_SIDE = bmp_pkg::MAX_BLOCKS_PER_SIDE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_frame_start,
   input  logic [bmp_pkg::CHAN_BITS-1:0]     req_red,
   input  logic [bmp_pkg::CHAN_BITS-1:0]     req_green,
   input  logic [bmp_pkg::CHAN_BITS-1:0]     req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bmp_pkg::GRID_IDX_BITS-1:0] rsp_block_row,
   output logic [bmp_pkg::GRID_IDX_BITS-1:0] rsp_block_col,
   output logic [bmp_pkg::CHAN_BITS-1:0]     rsp_mean_red,
   output logic [bmp_pkg::CHAN_BITS-1:0]     rsp_mean_green,
   output logic [bmp_pkg::CHAN_BITS-1:0]     rsp_mean_blue,
   output logic                              rsp_frame_done,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bmp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [bmp_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [bmp_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int CB = $clog2(MAX_IMAGE_WIDTH + 1);
   localparam int DW = (CB > bmp_pkg::ROW_BITS) ? CB : bmp_pkg::ROW_BITS;
   localparam int EW = (DW > bmp_pkg::WIDTH_REG_BITS) ? DW : bmp_pkg::WIDTH_REG_BITS;
   localparam int BW = $clog2(MAX_BLOCKS_PER_SIDE + 1);
   localparam int EB = (BW > bmp_pkg::BLOCKS_REG_BITS) ? BW : bmp_pkg::BLOCKS_REG_BITS;
   localparam int AW = (MAX_BLOCKS_PER_SIDE > 1) ? $clog2(MAX_BLOCKS_PER_SIDE) : 1;
   localparam int AREA_W = 2 * DW;
   localparam int SB = bmp_pkg::SUM_BITS;
   localparam int CH = bmp_pkg::CHAN_BITS;
   localparam int NC = bmp_pkg::NUM_CHAN;
   localparam int RAM_W = NC * SB;
   localparam int STEPS_MAX = (DW > SB) ? DW : SB;
   localparam int CNT_W = $clog2(STEPS_MAX);
   localparam int SIDE_RESET = bmp_pkg::WIDTH_RESET / bmp_pkg::BLOCKS_RESET;

   // configuration
   logic [bmp_pkg::WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [bmp_pkg::BLOCKS_REG_BITS-1:0] blocks_ff, blocks_in;
   logic                                cfg_we;
   logic [EW-1:0] width_x;
   logic [EB-1:0] blocks_x;
   logic [DW-1:0] eff_w;
   logic [DW-1:0] eff_b;

   // position tracking
   logic [DW-1:0] col_ff, row_ff, cin_ff, rin_ff, bc_ff, br_ff;
   logic          past_ff;
   logic [DW-1:0] cur_col, cur_row, cur_cin, cur_rin, cur_bc, cur_br;
   logic          cur_past;
   logic [DW-1:0] side_ff;
   logic [AREA_W-1:0] area_ff;
   logic          in_grid, accept;

   // item latched at accept
   logic          it_emit_ff, it_load_ff, it_fd_ff;
   logic [AW-1:0] it_k_ff;
   logic [DW-1:0] it_br_ff, it_bc_ff;
   logic [CH-1:0] it_pix_ff [NC];
   logic [MAX_BLOCKS_PER_SIDE-1:0] vld_ff;

   // memory
   logic [RAM_W-1:0] ram_rdata, ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic             ram_we;
   logic [SB-1:0]    sum_new [NC];

   // shared position divider
   logic [DW-1:0] div_num_ff, div_den_ff, div_rem_ff, div_quo_ff;
   logic [DW:0]   div_t, div_d;
   logic          div_ge;
   logic [DW-1:0] div_rem_nx, div_quo_nx;

   // mean divider
   logic [SB-1:0]     mnum_ff [NC];
   logic [AREA_W-1:0] mrem_ff [NC];
   logic [CH-1:0]     mq_ff [NC];

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last;
   logic             out_free;
   bmp_pkg::bmp_state_type state_ff, state_in;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in = width_ff;
      blocks_in = blocks_ff;
      if (cfg_we) begin
         unique case (bmp_pkg::bmp_reg_type'(csr_paddr[2]))
            bmp_pkg::REG_IMAGE_WIDTH:
               width_in = csr_pwdata[bmp_pkg::WIDTH_REG_BITS-1:0];
            bmp_pkg::REG_BLOCKS_PER_SIDE:
               blocks_in = csr_pwdata[bmp_pkg::BLOCKS_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (bmp_pkg::bmp_reg_type'(csr_paddr[2]))
         bmp_pkg::REG_IMAGE_WIDTH:
            csr_prdata[bmp_pkg::WIDTH_REG_BITS-1:0] = width_ff;
         bmp_pkg::REG_BLOCKS_PER_SIDE:
            csr_prdata[bmp_pkg::BLOCKS_REG_BITS-1:0] = blocks_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= bmp_pkg::WIDTH_REG_BITS'(bmp_pkg::WIDTH_RESET);
         blocks_ff <= bmp_pkg::BLOCKS_REG_BITS'(bmp_pkg::BLOCKS_RESET);
      end else begin
         width_ff <= width_in;
         blocks_ff <= blocks_in;
      end
   end

   // clamped values, taken from the next register value so a divide can start at once
   always_comb begin
      width_x = EW'(width_in);
      if (width_x == '0) width_x = EW'(1);
      else if (width_x > EW'(MAX_IMAGE_WIDTH)) width_x = EW'(MAX_IMAGE_WIDTH);
      blocks_x = EB'(blocks_in);
      if (blocks_x == '0) blocks_x = EB'(1);
      else if (blocks_x > EB'(MAX_BLOCKS_PER_SIDE)) blocks_x = EB'(MAX_BLOCKS_PER_SIDE);
      eff_w = width_x[DW-1:0];
      eff_b = DW'(blocks_x);
   end

   // ---------------- position and grid decode ----------------
   always_comb begin
      if (req_frame_start) begin
         cur_col = '0; cur_row = '0; cur_cin = '0; cur_rin = '0;
         cur_bc = '0; cur_br = '0; cur_past = 1'b0;
      end else begin
         cur_col = col_ff; cur_row = row_ff; cur_cin = cin_ff; cur_rin = rin_ff;
         cur_bc = bc_ff; cur_br = br_ff; cur_past = past_ff;
      end
      in_grid = !cur_past && (side_ff != '0) && (cur_bc < eff_b) && (cur_br < eff_b);
   end

   assign accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; cin_ff <= '0; rin_ff <= '0;
         bc_ff <= '0; br_ff <= '0; past_ff <= 1'b0;
      end else if (accept) begin
         if ({1'b0, cur_col} + (DW+1)'(1) >= {1'b0, eff_w}) begin
            col_ff <= '0;
            cin_ff <= '0;
            bc_ff <= '0;
            if (cur_row >= DW'(bmp_pkg::ROW_LIMIT)) begin
               past_ff <= 1'b1;
               row_ff <= cur_row; rin_ff <= cur_rin; br_ff <= cur_br;
            end else begin
               past_ff <= cur_past;
               row_ff <= cur_row + DW'(1);
               if (cur_rin + DW'(1) == side_ff) begin
                  rin_ff <= '0;
                  br_ff <= cur_br + DW'(1);
               end else begin
                  rin_ff <= cur_rin + DW'(1);
                  br_ff <= cur_br;
               end
            end
         end else begin
            col_ff <= cur_col + DW'(1);
            row_ff <= cur_row; rin_ff <= cur_rin; br_ff <= cur_br; past_ff <= cur_past;
            if (cur_cin + DW'(1) == side_ff) begin
               cin_ff <= '0;
               bc_ff <= cur_bc + DW'(1);
            end else begin
               cin_ff <= cur_cin + DW'(1);
               bc_ff <= cur_bc;
            end
         end
      end else begin
         // re-derive block coordinates after a side change
         if (state_ff == bmp_pkg::ST_COL && last) begin
            cin_ff <= div_rem_nx;
            bc_ff <= div_quo_nx;
         end
         if (state_ff == bmp_pkg::ST_ROW && last) begin
            rin_ff <= div_rem_nx;
            br_ff <= div_quo_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= DW'(SIDE_RESET);
      end else if (state_ff == bmp_pkg::ST_SIDE && last && !cfg_we) begin
         side_ff <= div_quo_nx;
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(side_ff * side_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         it_emit_ff <= (cur_cin == side_ff - DW'(1)) && (cur_rin == side_ff - DW'(1));
         it_load_ff <= (cur_cin == '0) && (cur_rin == '0);
         it_fd_ff <= (cur_br == eff_b - DW'(1)) && (cur_bc == eff_b - DW'(1));
         it_k_ff <= cur_bc[AW-1:0];
         it_br_ff <= cur_br;
         it_bc_ff <= cur_bc;
         it_pix_ff[0] <= req_red;
         it_pix_ff[1] <= req_green;
         it_pix_ff[2] <= req_blue;
      end
   end

   // ---------------- column sums ----------------
   assign ram_raddr = cur_bc[AW-1:0];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         logic [SB-1:0] old;
         old = vld_ff[it_k_ff] ? ram_rdata[c*SB +: SB] : '0;
         sum_new[c] = it_load_ff ? SB'(it_pix_ff[c]) : old + SB'(it_pix_ff[c]);
         ram_wdata[c*SB +: SB] = sum_new[c];
      end
   end

   bmp_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_BLOCKS_PER_SIDE)
   ) u_sums (
      .clock(clock),
      .we(ram_we),
      .waddr(it_k_ff),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // entries not yet written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ram_we) begin
         vld_ff[it_k_ff] <= 1'b1;
      end
   end

   // ---------------- position divider, one quotient bit per cycle ----------------
   always_comb begin
      div_t = {div_rem_ff, div_num_ff[DW-1]};
      div_d = {1'b0, div_den_ff};
      div_ge = div_t >= div_d;
      div_rem_nx = div_ge ? DW'(div_t - div_d) : div_t[DW-1:0];
      div_quo_nx = {div_quo_ff[DW-2:0], div_ge};
   end

   always_ff @(posedge clock) begin
      if (cfg_we) begin
         div_num_ff <= eff_w;
         div_den_ff <= eff_b;
         div_rem_ff <= '0;
         div_quo_ff <= '0;
      end else if (state_ff == bmp_pkg::ST_SIDE && last) begin
         div_num_ff <= col_ff;
         div_den_ff <= div_quo_nx;
         div_rem_ff <= '0;
         div_quo_ff <= '0;
      end else if (state_ff == bmp_pkg::ST_COL && last) begin
         div_num_ff <= row_ff;
         div_rem_ff <= '0;
         div_quo_ff <= '0;
      end else begin
         div_num_ff <= div_num_ff << 1;
         div_rem_ff <= div_rem_nx;
         div_quo_ff <= div_quo_nx;
      end
   end

   // ---------------- mean divider, sum / side^2 for all channels ----------------
   // steps only in ST_MEAN so the quotient holds while the result waits
   always_ff @(posedge clock) begin
      if (state_ff == bmp_pkg::ST_UPDATE) begin
         for (int c = 0; c < NC; c++) begin
            mnum_ff[c] <= sum_new[c];
            mrem_ff[c] <= '0;
            mq_ff[c] <= '0;
         end
      end else if (state_ff == bmp_pkg::ST_MEAN) begin
         for (int c = 0; c < NC; c++) begin
            logic [AREA_W:0] t;
            logic            ge;
            t = {mrem_ff[c], mnum_ff[c][SB-1]};
            ge = t >= {1'b0, area_ff};
            mrem_ff[c] <= ge ? AREA_W'(t - {1'b0, area_ff}) : t[AREA_W-1:0];
            mq_ff[c] <= {mq_ff[c][CH-2:0], ge};
            mnum_ff[c] <= mnum_ff[c] << 1;
         end
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      unique case (state_ff)
         bmp_pkg::ST_MEAN: last = cnt_ff == CNT_W'(SB - 1);
         bmp_pkg::ST_SIDE,
         bmp_pkg::ST_COL,
         bmp_pkg::ST_ROW:  last = cnt_ff == CNT_W'(DW - 1);
         default:          last = 1'b0;
      endcase
   end

   assign out_free = !rsp_valid || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmp_pkg::ST_IDLE:   if (accept && in_grid) state_in = bmp_pkg::ST_UPDATE;
         bmp_pkg::ST_UPDATE: state_in = it_emit_ff ? bmp_pkg::ST_MEAN : bmp_pkg::ST_IDLE;
         bmp_pkg::ST_MEAN:   if (last) state_in = bmp_pkg::ST_OUT;
         bmp_pkg::ST_OUT:    if (out_free) state_in = bmp_pkg::ST_IDLE;
         bmp_pkg::ST_SIDE: begin
            if (last) state_in = (div_quo_nx != '0) ? bmp_pkg::ST_COL : bmp_pkg::ST_IDLE;
         end
         bmp_pkg::ST_COL:    if (last) state_in = bmp_pkg::ST_ROW;
         bmp_pkg::ST_ROW:    if (last) state_in = bmp_pkg::ST_IDLE;
         default:            state_in = bmp_pkg::ST_IDLE;
      endcase
      if (cfg_we) state_in = bmp_pkg::ST_SIDE;
      cnt_in = (state_in != state_ff || cfg_we) ? '0 : cnt_ff + CNT_W'(1);
   end

   always_comb begin
      req_stall = (state_ff != bmp_pkg::ST_IDLE) || cfg_we;
      ram_we = state_ff == bmp_pkg::ST_UPDATE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmp_pkg::ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (state_ff == bmp_pkg::ST_OUT && out_free) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bmp_pkg::ST_OUT && out_free) begin
         rsp_block_row <= it_br_ff[bmp_pkg::GRID_IDX_BITS-1:0];
         rsp_block_col <= it_bc_ff[bmp_pkg::GRID_IDX_BITS-1:0];
         rsp_mean_red <= mq_ff[0];
         rsp_mean_green <= mq_ff[1];
         rsp_mean_blue <= mq_ff[2];
         rsp_frame_done <= it_fd_ff;
      end
   end

endmodule
